// ===== src/nonuniform_bspline_eval_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the B-spline evaluator.
// ---------------------------------------------------------------------------
`ifndef NONUNIFORM_BSPLINE_EVAL_DEFINES_SVH
`define NONUNIFORM_BSPLINE_EVAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSPL_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bspline port check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSPL_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bspline port check failed");

`endif

// ===== src/bspl_pkg.sv =====
// ---------------------------------------------------------------------------
// bspl_pkg
// Types, constants and saturating helpers of the B-spline evaluator.
// ---------------------------------------------------------------------------
package bspl_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [31:0] word_t;
  typedef logic signed [32:0] diff_t;
  typedef logic        [31:0] den_t;
  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    word_t param_t;
    word_t knot_0;
    word_t knot_1;
    word_t knot_2;
    word_t knot_3;
    word_t knot_4;
    word_t knot_5;
    word_t control_point_0;
    word_t control_point_1;
    word_t control_point_2;
    word_t control_point_3;
  } in_item_t;

  typedef struct packed {
    word_t curve_value;
    logic  span_error;
  } out_item_t;

  localparam s64_t S64_MAX = {1'b0, {63{1'b1}}};
  localparam s64_t S64_MIN = {1'b1, {63{1'b0}}};

  // Magnitude of a signed 64-bit value; the most negative value maps to 2^63.
  function automatic logic [63:0] mag64(input s64_t x);
    logic [63:0] u;
    u = x;
    return x[63] ? (64'd0 - u) : u;
  endfunction

  // Signed result from sign and magnitude, saturated to 64 bits.
  function automatic s64_t sat_mag(input logic neg, input logic ovf, input logic [63:0] lo);
    s64_t r;
    if (neg) begin
      if (ovf || lo[63]) begin
        r = S64_MIN;
      end else begin
        r = s64_t'(64'd0 - lo);
      end
    end else begin
      if (ovf || lo[63]) begin
        r = S64_MAX;
      end else begin
        r = s64_t'(lo);
      end
    end
    return r;
  endfunction

  // Saturating 64-bit addition.
  function automatic s64_t sat_add(input s64_t a, input s64_t b);
    s64_t s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

endpackage

// ===== src/nonuniform_bspline_eval.sv =====
// ---------------------------------------------------------------------------
// nonuniform_bspline_eval
// Nonuniform cubic B-spline segment evaluator, fully pipelined, Q16.16.
// ---------------------------------------------------------------------------
//
//   Channel | Ports                          | Payload
//   --------+--------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data    | parameter, six knots, four points
//   result  | out_valid, out_ready, out_data | curve value, span error flag
//
// One item can be accepted every cycle while the output queue has room;
// an item passes three chained bit-serial dividers of FRAC_BITS+66 stages
// each plus three multipliers. Reset clears only the valid bits and the
// output queue; no clearing pass. The whole pipeline advances together;
// it holds only while the two-entry output queue is full, so an item is
// still taken while a result waits.
// ---------------------------------------------------------------------------
module nonuniform_bspline_eval #(
  parameter int FRAC_BITS = bspl_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bspl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bspl_pkg::out_item_t out_data
);
  import bspl_pkg::*;

  // Side data that travels along with each arithmetic group.
  typedef struct packed {
    logic         err;
    diff_t [5:0]  d;
    den_t         s31;
    den_t         s42;
    den_t         s30;
    den_t         s41;
    den_t         s52;
    word_t [3:0]  p;
  } tag1_t;

  typedef struct packed {
    logic         err;
    diff_t [5:0]  d;
    den_t         s30;
    den_t         s41;
    den_t         s52;
    word_t [3:0]  p;
  } tag2_t;

  typedef struct packed {
    logic         err;
    diff_t [5:0]  d;
    word_t [3:0]  p;
  } tag4_t;

  typedef struct packed {
    logic         err;
    word_t [3:0]  p;
  } tag5_t;

  function automatic diff_t sub33(input word_t a, input word_t b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic s64_t ext33(input diff_t x);
    return {{31{x[32]}}, x};
  endfunction

  function automatic s64_t ext32(input word_t x);
    return {{32{x[31]}}, x};
  endfunction

  // A knot span is bad when its difference is zero or negative.
  function automatic logic bad_span(input diff_t s);
    return s[32] || (s == '0);
  endfunction

  // -------------------------------------------------------------------------
  // Global advance. The pipeline moves whenever the output queue has room.
  // -------------------------------------------------------------------------
  logic       en;
  logic [1:0] q_cnt_r;
  logic [1:0] q_cnt_nxt;

  assign en       = (q_cnt_r != 2'd2);
  assign in_ready = en;

  // -------------------------------------------------------------------------
  // Stage P1: knot differences, parameter offsets and the span check.
  // -------------------------------------------------------------------------
  diff_t s32_w, s31_w, s42_w, s30_w, s41_w, s52_w;
  tag1_t p1_tag_nxt;
  tag1_t p1_tag_r;
  den_t  p1_s32_r;
  logic  p1_vld_r;

  always_comb begin
    s32_w = sub33(in_data.knot_3, in_data.knot_2);
    s31_w = sub33(in_data.knot_3, in_data.knot_1);
    s42_w = sub33(in_data.knot_4, in_data.knot_2);
    s30_w = sub33(in_data.knot_3, in_data.knot_0);
    s41_w = sub33(in_data.knot_4, in_data.knot_1);
    s52_w = sub33(in_data.knot_5, in_data.knot_2);

    p1_tag_nxt.err  = bad_span(s32_w) || bad_span(s31_w) || bad_span(s42_w) ||
                      bad_span(s30_w) || bad_span(s41_w) || bad_span(s52_w);
    p1_tag_nxt.d[0] = sub33(in_data.param_t, in_data.knot_0);
    p1_tag_nxt.d[1] = sub33(in_data.param_t, in_data.knot_1);
    p1_tag_nxt.d[2] = sub33(in_data.param_t, in_data.knot_2);
    p1_tag_nxt.d[3] = sub33(in_data.knot_3, in_data.param_t);
    p1_tag_nxt.d[4] = sub33(in_data.knot_4, in_data.param_t);
    p1_tag_nxt.d[5] = sub33(in_data.knot_5, in_data.param_t);
    // Spans are only used as divisors when all are positive, so the low
    // 32 bits carry them exactly.
    p1_tag_nxt.s31  = s31_w[31:0];
    p1_tag_nxt.s42  = s42_w[31:0];
    p1_tag_nxt.s30  = s30_w[31:0];
    p1_tag_nxt.s41  = s41_w[31:0];
    p1_tag_nxt.s52  = s52_w[31:0];
    p1_tag_nxt.p[0] = in_data.control_point_0;
    p1_tag_nxt.p[1] = in_data.control_point_1;
    p1_tag_nxt.p[2] = in_data.control_point_2;
    p1_tag_nxt.p[3] = in_data.control_point_3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_tag_r <= p1_tag_nxt;
      p1_s32_r <= s32_w[31:0];
    end
  end

  // -------------------------------------------------------------------------
  // Group 1: d3/(k3-k2) and d2/(k3-k2).
  // -------------------------------------------------------------------------
  s64_t g1_num [2];
  den_t g1_den [2];
  s64_t g1_quo [2];
  logic [$bits(tag1_t)-1:0] g1_tag;
  logic  g1_vld;
  tag1_t t1;

  always_comb begin
    g1_num[0] = ext33(p1_tag_r.d[3]);
    g1_num[1] = ext33(p1_tag_r.d[2]);
    g1_den[0] = p1_s32_r;
    g1_den[1] = p1_s32_r;
  end

  bspl_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .TAG_W($bits(tag1_t))) u_div_g1 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(p1_vld_r),
    .num_i(g1_num), .den_i(g1_den), .tag_i(p1_tag_r),
    .vld_o(g1_vld), .quo_o(g1_quo), .tag_o(g1_tag)
  );

  assign t1 = tag1_t'(g1_tag);

  // -------------------------------------------------------------------------
  // Group 2: a = ../(k3-k1), b = ../(k4-k2).
  // -------------------------------------------------------------------------
  den_t  g2_den [2];
  s64_t  g2_quo [2];
  tag2_t g2_tag_in;
  logic [$bits(tag2_t)-1:0] g2_tag;
  logic  g2_vld;
  tag2_t t2;

  always_comb begin
    g2_den[0]     = t1.s31;
    g2_den[1]     = t1.s42;
    g2_tag_in.err = t1.err;
    g2_tag_in.d   = t1.d;
    g2_tag_in.s30 = t1.s30;
    g2_tag_in.s41 = t1.s41;
    g2_tag_in.s52 = t1.s52;
    g2_tag_in.p   = t1.p;
  end

  bspl_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .TAG_W($bits(tag2_t))) u_div_g2 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(g1_vld),
    .num_i(g1_quo), .den_i(g2_den), .tag_i(g2_tag_in),
    .vld_o(g2_vld), .quo_o(g2_quo), .tag_o(g2_tag)
  );

  assign t2 = tag2_t'(g2_tag);

  // -------------------------------------------------------------------------
  // Group 3: d3*a, d1*a, d4*b, d2*b.
  // -------------------------------------------------------------------------
  s64_t g3_a [4];
  s64_t g3_b [4];
  s64_t g3_m [4];
  logic [$bits(tag2_t)-1:0] g3_tag;
  logic  g3_vld;

  always_comb begin
    g3_a[0] = ext33(t2.d[3]);
    g3_a[1] = ext33(t2.d[1]);
    g3_a[2] = ext33(t2.d[4]);
    g3_a[3] = ext33(t2.d[2]);
    g3_b[0] = g2_quo[0];
    g3_b[1] = g2_quo[0];
    g3_b[2] = g2_quo[1];
    g3_b[3] = g2_quo[1];
  end

  bspl_mul #(.FRAC_BITS(FRAC_BITS), .LANES(4), .TAG_W($bits(tag2_t))) u_mul_g3 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(g2_vld),
    .a_i(g3_a), .b_i(g3_b), .tag_i(g2_tag),
    .vld_o(g3_vld), .prod_o(g3_m), .tag_o(g3_tag)
  );

  // Stage X: numerators of c, e and f; e needs one saturating sum.
  s64_t  x_num_r [3];
  tag2_t x_tag_r;
  logic  x_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else if (en) begin
      x_vld_r <= g3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_num_r[0] <= g3_m[0];
      x_num_r[1] <= sat_add(g3_m[1], g3_m[2]);
      x_num_r[2] <= g3_m[3];
      x_tag_r    <= tag2_t'(g3_tag);
    end
  end

  // -------------------------------------------------------------------------
  // Group 4: c, e and f.
  // -------------------------------------------------------------------------
  den_t  g4_den [3];
  s64_t  g4_quo [3];
  tag4_t g4_tag_in;
  logic [$bits(tag4_t)-1:0] g4_tag;
  logic  g4_vld;
  tag4_t t4;

  always_comb begin
    g4_den[0]     = x_tag_r.s30;
    g4_den[1]     = x_tag_r.s41;
    g4_den[2]     = x_tag_r.s52;
    g4_tag_in.err = x_tag_r.err;
    g4_tag_in.d   = x_tag_r.d;
    g4_tag_in.p   = x_tag_r.p;
  end

  bspl_div #(.FRAC_BITS(FRAC_BITS), .LANES(3), .TAG_W($bits(tag4_t))) u_div_g4 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(x_vld_r),
    .num_i(x_num_r), .den_i(g4_den), .tag_i(g4_tag_in),
    .vld_o(g4_vld), .quo_o(g4_quo), .tag_o(g4_tag)
  );

  assign t4 = tag4_t'(g4_tag);

  // -------------------------------------------------------------------------
  // Group 5: the six products that form the basis weights.
  // -------------------------------------------------------------------------
  s64_t  g5_a [6];
  s64_t  g5_b [6];
  s64_t  g5_m [6];
  tag5_t g5_tag_in;
  logic [$bits(tag5_t)-1:0] g5_tag;
  logic  g5_vld;

  always_comb begin
    g5_a[0] = ext33(t4.d[3]);
    g5_a[1] = ext33(t4.d[0]);
    g5_a[2] = ext33(t4.d[4]);
    g5_a[3] = ext33(t4.d[1]);
    g5_a[4] = ext33(t4.d[5]);
    g5_a[5] = ext33(t4.d[2]);
    g5_b[0] = g4_quo[0];
    g5_b[1] = g4_quo[0];
    g5_b[2] = g4_quo[1];
    g5_b[3] = g4_quo[1];
    g5_b[4] = g4_quo[2];
    g5_b[5] = g4_quo[2];
    g5_tag_in.err = t4.err;
    g5_tag_in.p   = t4.p;
  end

  bspl_mul #(.FRAC_BITS(FRAC_BITS), .LANES(6), .TAG_W($bits(tag5_t))) u_mul_g5 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(g4_vld),
    .a_i(g5_a), .b_i(g5_b), .tag_i(g5_tag_in),
    .vld_o(g5_vld), .prod_o(g5_m), .tag_o(g5_tag)
  );

  // Stage Y: basis weights N0..N3.
  s64_t  y_n_r [4];
  tag5_t y_tag_r;
  logic  y_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r <= 1'b0;
    end else if (en) begin
      y_vld_r <= g5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_n_r[0] <= g5_m[0];
      y_n_r[1] <= sat_add(g5_m[1], g5_m[2]);
      y_n_r[2] <= sat_add(g5_m[3], g5_m[4]);
      y_n_r[3] <= g5_m[5];
      y_tag_r  <= tag5_t'(g5_tag);
    end
  end

  // -------------------------------------------------------------------------
  // Group 6: weights times control points.
  // -------------------------------------------------------------------------
  s64_t g6_b [4];
  s64_t g6_m [4];
  logic g6_err;
  logic g6_vld;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      g6_b[i] = ext32(y_tag_r.p[i]);
    end
  end

  bspl_mul #(.FRAC_BITS(FRAC_BITS), .LANES(4), .TAG_W(1)) u_mul_g6 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(y_vld_r),
    .a_i(y_n_r), .b_i(g6_b), .tag_i(y_tag_r.err),
    .vld_o(g6_vld), .prod_o(g6_m), .tag_o(g6_err)
  );

  // Stages Z1..Z3: the final sum is taken strictly left to right, since
  // saturating addition does not reassociate.
  s64_t z1_v_r, z1_m2_r, z1_m3_r, z2_v_r, z2_m3_r, z3_v_r;
  logic z1_err_r, z2_err_r, z3_err_r;
  logic z1_vld_r, z2_vld_r, z3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_vld_r <= 1'b0;
      z2_vld_r <= 1'b0;
      z3_vld_r <= 1'b0;
    end else if (en) begin
      z1_vld_r <= g6_vld;
      z2_vld_r <= z1_vld_r;
      z3_vld_r <= z2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_v_r   <= sat_add(g6_m[0], g6_m[1]);
      z1_m2_r  <= g6_m[2];
      z1_m3_r  <= g6_m[3];
      z1_err_r <= g6_err;
      z2_v_r   <= sat_add(z1_v_r, z1_m2_r);
      z2_m3_r  <= z1_m3_r;
      z2_err_r <= z1_err_r;
      z3_v_r   <= sat_add(z2_v_r, z2_m3_r);
      z3_err_r <= z2_err_r;
    end
  end

  // Clamp to 32 bits; a bad span forces the value to zero.
  out_item_t res;

  always_comb begin
    res.span_error = z3_err_r;
    if (z3_err_r) begin
      res.curve_value = '0;
    end else if (z3_v_r[63:31] == {33{z3_v_r[63]}}) begin
      res.curve_value = z3_v_r[31:0];
    end else if (z3_v_r[63]) begin
      res.curve_value = {1'b1, {31{1'b0}}};
    end else begin
      res.curve_value = {1'b0, {31{1'b1}}};
    end
  end

  // -------------------------------------------------------------------------
  // Two-entry output queue. Entry 0 is the head shown on the result port.
  // A push only happens while the queue has room.
  // -------------------------------------------------------------------------
  out_item_t q_data_r [2];
  logic      push;
  logic      pop;

  assign push = en && z3_vld_r;
  assign pop  = out_valid && out_ready;

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (push && !pop) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (pop && !push) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (q_cnt_r == 2'd1)) begin
        q_data_r[0] <= res;
      end else begin
        q_data_r[0] <= q_data_r[1];
        if (push) begin
          q_data_r[1] <= res;
        end
      end
    end else if (push) begin
      if (q_cnt_r == 2'd0) begin
        q_data_r[0] <= res;
      end else begin
        q_data_r[1] <= res;
      end
    end
  end

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_data  = q_data_r[0];

endmodule

// ===== src/bspl_div.sv =====
// ---------------------------------------------------------------------------
// bspl_div
// Pipelined fixed-point divider, one quotient bit per stage, several lanes.
// ---------------------------------------------------------------------------
module bspl_div #(
  parameter int FRAC_BITS = bspl_pkg::FRAC_BITS_DEF,
  parameter int LANES     = 1,
  parameter int TAG_W     = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  bspl_pkg::s64_t       num_i [LANES],
  input  bspl_pkg::den_t       den_i [LANES],
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 vld_o,
  output bspl_pkg::s64_t       quo_o [LANES],
  output logic [TAG_W-1:0]     tag_o
);
  import bspl_pkg::*;

  localparam int NW    = 64 + FRAC_BITS;
  localparam int STEPS = NW;

  logic [NW-1:0]    num_r [STEPS+1][LANES];
  den_t             rem_r [STEPS+1][LANES];
  den_t             den_r [STEPS+1][LANES];
  logic [63:0]      quo_r [STEPS+1][LANES];
  logic             ovf_r [STEPS+1][LANES];
  logic             neg_r [STEPS+1][LANES];
  logic [TAG_W-1:0] tag_r [STEPS+1];
  logic [STEPS:0]   vld_r;

  s64_t             res_r [LANES];
  logic [TAG_W-1:0] res_tag_r;
  logic             res_vld_r;

  // Entry stage: split sign and magnitude, scale the magnitude.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en_i) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      tag_r[0] <= tag_i;
      for (int l = 0; l < LANES; l++) begin
        neg_r[0][l] <= num_i[l][63];
        num_r[0][l] <= {mag64(num_i[l]), {FRAC_BITS{1'b0}}};
        rem_r[0][l] <= '0;
        quo_r[0][l] <= '0;
        ovf_r[0][l] <= 1'b0;
        den_r[0][l] <= den_i[l];
      end
    end
  end

  // Restoring division steps. Quotient bits that leave the 64-bit window
  // are folded into the overflow flag.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [32:0] trial;
      logic [32:0] diff;
      logic        ge;
      den_t        rem_nxt;

      assign trial   = {rem_r[k][l], num_r[k][l][NW-1]};
      assign diff    = trial - {1'b0, den_r[k][l]};
      assign ge      = trial >= {1'b0, den_r[k][l]};
      assign rem_nxt = ge ? diff[31:0] : trial[31:0];

      always_ff @(posedge clk) begin
        if (en_i) begin
          num_r[k+1][l] <= {num_r[k][l][NW-2:0], 1'b0};
          rem_r[k+1][l] <= rem_nxt;
          quo_r[k+1][l] <= {quo_r[k][l][62:0], ge};
          ovf_r[k+1][l] <= ovf_r[k][l] | quo_r[k][l][63];
          neg_r[k+1][l] <= neg_r[k][l];
          den_r[k+1][l] <= den_r[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  // Output stage: restore the sign and saturate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (en_i) begin
      res_vld_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      res_tag_r <= tag_r[STEPS];
      for (int l = 0; l < LANES; l++) begin
        res_r[l] <= sat_mag(neg_r[STEPS][l], ovf_r[STEPS][l], quo_r[STEPS][l]);
      end
    end
  end

  assign vld_o = res_vld_r;
  assign tag_o = res_tag_r;
  assign quo_o = res_r;

endmodule

// ===== src/bspl_mul.sv =====
// ---------------------------------------------------------------------------
// bspl_mul
// Five-stage fixed-point multiplier from 32x32 partial products, several lanes.
// ---------------------------------------------------------------------------
module bspl_mul #(
  parameter int FRAC_BITS = bspl_pkg::FRAC_BITS_DEF,
  parameter int LANES     = 1,
  parameter int TAG_W     = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  bspl_pkg::s64_t       a_i [LANES],
  input  bspl_pkg::s64_t       b_i [LANES],
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 vld_o,
  output bspl_pkg::s64_t       prod_o [LANES],
  output logic [TAG_W-1:0]     tag_o
);
  import bspl_pkg::*;

  localparam int DEPTH = 5;

  logic [DEPTH-1:0] vld_r;
  logic [TAG_W-1:0] tag_r [DEPTH];

  logic [63:0]  ma_r   [LANES];
  logic [63:0]  mb_r   [LANES];
  logic         neg1_r [LANES];
  logic [63:0]  p00_r  [LANES];
  logic [63:0]  p01_r  [LANES];
  logic [63:0]  p10_r  [LANES];
  logic [63:0]  p11_r  [LANES];
  logic         neg2_r [LANES];
  logic [63:0]  lo3_r  [LANES];
  logic [63:0]  hi3_r  [LANES];
  logic [64:0]  mid3_r [LANES];
  logic         neg3_r [LANES];
  logic [127:0] full4_r[LANES];
  logic         neg4_r [LANES];
  s64_t         prod_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en_i) begin
      vld_r <= {vld_r[DEPTH-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      tag_r[0] <= tag_i;
      for (int s = 1; s < DEPTH; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        // Stage 1: magnitudes and product sign.
        ma_r[l]   <= mag64(a_i[l]);
        mb_r[l]   <= mag64(b_i[l]);
        neg1_r[l] <= a_i[l][63] ^ b_i[l][63];
        // Stage 2: four 32x32 partial products.
        p00_r[l]  <= ma_r[l][31:0]  * mb_r[l][31:0];
        p01_r[l]  <= ma_r[l][31:0]  * mb_r[l][63:32];
        p10_r[l]  <= ma_r[l][63:32] * mb_r[l][31:0];
        p11_r[l]  <= ma_r[l][63:32] * mb_r[l][63:32];
        neg2_r[l] <= neg1_r[l];
        // Stage 3: fold the cross terms.
        lo3_r[l]  <= p00_r[l];
        hi3_r[l]  <= p11_r[l];
        mid3_r[l] <= {1'b0, p01_r[l]} + {1'b0, p10_r[l]};
        neg3_r[l] <= neg2_r[l];
        // Stage 4: full 128-bit magnitude.
        full4_r[l] <= {hi3_r[l], lo3_r[l]} + {31'd0, mid3_r[l], 32'd0};
        neg4_r[l]  <= neg3_r[l];
        // Stage 5: drop fraction bits, restore sign, saturate.
        prod_r[l] <= sat_mag(neg4_r[l], |full4_r[l][127:64+FRAC_BITS],
                             full4_r[l][FRAC_BITS +: 64]);
      end
    end
  end

  assign vld_o  = vld_r[DEPTH-1];
  assign tag_o  = tag_r[DEPTH-1];
  assign prod_o = prod_r;

endmodule

// ===== src/bspl_chk.sv =====
// ---------------------------------------------------------------------------
// bspl_chk
// Port-level checks of the B-spline evaluator, bound to the top level.
// ---------------------------------------------------------------------------
`include "nonuniform_bspline_eval_defines.svh"

module bspl_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bspl_pkg::out_item_t out_data
);
  import bspl_pkg::*;

  // A waiting result holds until it is taken.
  `BSPL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // A bad span always reports a zero value.
  `BSPL_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_data.span_error, out_data.curve_value == '0)

  // With nothing queued at the output, the input side must be open.
  `BSPL_ASSERT_NOW(a_empty_ready, clk, rst_n, !out_valid, in_ready)

  // A result transfer always frees room for the next input item.
  `BSPL_ASSERT_NEXT(a_pop_ready, clk, rst_n, out_valid && out_ready, in_ready)

endmodule

bind nonuniform_bspline_eval bspl_chk u_bspl_chk (.*);

// ===== verif/nonuniform_bspline_eval_test.sv =====
// ---------------------------------------------------------------------------
// nonuniform_bspline_eval_test
// Self-checking bench for the nonuniform cubic B-spline segment evaluator.
// It drives parameter, knot and control-point items through the input
// channel, predicts each curve value and span error flag in the bench, and
// compares every result transfer against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module nonuniform_bspline_eval_test;

  import bspl_pkg::*;

  localparam int FB         = FRAC_BITS_DEF;
  localparam int LATENCY    = 3 * FB + 220;
  localparam int WATCH_LIMIT = 20 * LATENCY + 2000;
  localparam int HOLD_CYCLES = 2 * LATENCY;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Predicted results, oldest first.
  out_item_t expected_curves[$];
  int        error_count;
  int        idle_cycles;
  // Once set, the receiver holds off in its own process and then clears it.
  bit        hold_results;
  bit        sink_random;

  nonuniform_bspline_eval DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Fixed-point arithmetic of the prediction. Every product and quotient is
  // formed on the exact value at 128 bits, truncated toward zero, and then
  // saturated to 64 bits.
  // -------------------------------------------------------------------------
  function automatic s64_t clamp128(input logic signed [127:0] x);
    if (x > 128'sh7fffffffffffffff) begin
      return S64_MAX;
    end
    if (x < -128'sh8000000000000000) begin
      return S64_MIN;
    end
    return s64_t'(x[63:0]);
  endfunction

  function automatic s64_t qmul(input s64_t a, input s64_t b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    // Truncate toward zero, not toward minus infinity.
    if (p < 0) begin
      p = -((-p) >>> FB);
    end else begin
      p = p >>> FB;
    end
    return clamp128(p);
  endfunction

  function automatic s64_t qdiv(input s64_t a, input s64_t den);
    logic signed [127:0] n;
    n = 128'(a) <<< FB;
    // SystemVerilog division truncates toward zero.
    return clamp128(n / 128'(den));
  endfunction

  function automatic s64_t qadd(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    return clamp128(128'(s));
  endfunction

  function automatic out_item_t eval_segment(input in_item_t it);
    out_item_t r;
    s64_t k0, k1, k2, k3, k4, k5, t;
    s64_t s32, s31, s42, s30, s41, s52;
    s64_t d0, d1, d2, d3, d4, d5, a, b, c, e, f, n0, n1, n2, n3, v;
    t  = it.param_t;
    k0 = it.knot_0;  k1 = it.knot_1;  k2 = it.knot_2;
    k3 = it.knot_3;  k4 = it.knot_4;  k5 = it.knot_5;
    s32 = k3 - k2;  s31 = k3 - k1;  s42 = k4 - k2;
    s30 = k3 - k0;  s41 = k4 - k1;  s52 = k5 - k2;
    r = '0;
    if (s32 <= 0 || s31 <= 0 || s42 <= 0 || s30 <= 0 || s41 <= 0 || s52 <= 0) begin
      r.span_error = 1'b1;
      return r;
    end
    d0 = t - k0;  d1 = t - k1;  d2 = t - k2;
    d3 = k3 - t;  d4 = k4 - t;  d5 = k5 - t;
    a = qdiv(qdiv(d3, s32), s31);
    b = qdiv(qdiv(d2, s32), s42);
    c = qdiv(qmul(d3, a), s30);
    e = qdiv(qadd(qmul(d1, a), qmul(d4, b)), s41);
    f = qdiv(qmul(d2, b), s52);
    n0 = qmul(d3, c);
    n1 = qadd(qmul(d0, c), qmul(d4, e));
    n2 = qadd(qmul(d1, e), qmul(d5, f));
    n3 = qmul(d2, f);
    v = qmul(n0, s64_t'(it.control_point_0));
    v = qadd(v, qmul(n1, s64_t'(it.control_point_1)));
    v = qadd(v, qmul(n2, s64_t'(it.control_point_2)));
    v = qadd(v, qmul(n3, s64_t'(it.control_point_3)));
    if (v > 64'sh7fffffff) begin
      v = 64'sh7fffffff;
    end else if (v < -64'sh80000000) begin
      v = -64'sh80000000;
    end
    r.curve_value = word_t'(v[31:0]);
    return r;
  endfunction

  // Offers one item, holds it until the transfer, and records the prediction.
  // The idle gap is drawn per item; gap zero keeps valid high back to back.
  task automatic send_segment(input in_item_t it, input int gap_max = 9);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_curves.push_back(eval_segment(it));
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    end_burst();
    while (expected_curves.size() != 0) @(negedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(3, 0))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(64, 0) << 12) - 32'sh40000;
      2: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
      default: return word_t'($signed($urandom_range(20, 0)) - 10) <<< FB;
    endcase
  endfunction

  // A well-formed window: ascending knots with random, mostly small steps
  // so the basis weights stay in range, and a parameter near the span.
  function automatic in_item_t rand_segment();
    in_item_t it;
    logic signed [63:0] k;
    int step;
    it = '0;
    k = 64'(word_t'($urandom)) >>> $urandom_range(12, 0);
    it.knot_0 = word_t'(k);
    for (int i = 1; i < 6; i++) begin
      step = $urandom_range(3, 0) == 0 ? $urandom_range(65536 * 8, 1)
                                      : $urandom_range(65536 * 2, 256);
      if ($urandom_range(9, 0) == 0) begin
        step = $urandom_range(1, 0);   // coincident knot or tiny step
      end
      k = k + step;
      if (k > 64'sh7fffffff) begin
        k = 64'sh7fffffff;
      end
      case (i)
        1: it.knot_1 = word_t'(k);
        2: it.knot_2 = word_t'(k);
        3: it.knot_3 = word_t'(k);
        4: it.knot_4 = word_t'(k);
        default: it.knot_5 = word_t'(k);
      endcase
    end
    it.param_t = it.knot_2 + word_t'($urandom_range(65536 * 3, 0))
                 - word_t'($urandom_range(65536, 0));
    it.control_point_0 = rand_word();
    it.control_point_1 = rand_word();
    it.control_point_2 = rand_word();
    it.control_point_3 = rand_word();
    return it;
  endfunction

  function automatic in_item_t noise_segment();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic in_item_t basic_segment(input word_t t, input word_t cp);
    in_item_t it;
    it.param_t = t;
    it.knot_0 = 32'sh0; it.knot_1 = 32'sh10000; it.knot_2 = 32'sh20000;
    it.knot_3 = 32'sh30000; it.knot_4 = 32'sh40000; it.knot_5 = 32'sh50000;
    it.control_point_0 = cp; it.control_point_1 = cp;
    it.control_point_2 = cp; it.control_point_3 = cp;
    return it;
  endfunction

  // -------------------------------------------------------------------------
  // Test tasks.
  // -------------------------------------------------------------------------

  // Uniform knots, the span ends, extrapolation both ways, extreme fields,
  // and bad-span cases with each denominator zero in turn.
  task automatic test_directed();
    in_item_t it;
    send_segment(basic_segment(32'sh20000, 32'sh10000));
    send_segment(basic_segment(32'sh30000, 32'sh10000));
    send_segment(basic_segment(32'sh28000, 32'sh7fffffff));
    send_segment(basic_segment(32'sh28000, 32'sh80000000));
    send_segment(basic_segment(32'sh7fffffff, 32'sh7fffffff));
    send_segment(basic_segment(32'sh80000000, 32'sh7fffffff));
    send_segment(basic_segment(-32'sh100000, 32'sh10000));
    it = basic_segment(32'sh24000, 32'sh0);
    it.control_point_0 = 32'sh10000; it.control_point_1 = 32'sh80000000;
    it.control_point_2 = 32'sh7fffffff; it.control_point_3 = -32'sh10000;
    send_segment(it);
    // Widest legal window with all-ones and all-zeros patterns.
    it.knot_0 = 32'sh80000000; it.knot_1 = 32'sh80000001; it.knot_2 = 32'sh80000002;
    it.knot_3 = 32'sh7ffffffd; it.knot_4 = 32'sh7ffffffe; it.knot_5 = 32'sh7fffffff;
    it.param_t = 32'sh0;
    send_segment(it);
    it.param_t = 32'sh7fffffff;
    send_segment(it);
    // Tiny spans blow up the quotients.
    it = basic_segment(32'sh7fffffff, 32'sh7fffffff);
    it.knot_1 = 32'sh1; it.knot_2 = 32'sh2; it.knot_3 = 32'sh3;
    it.knot_4 = 32'sh4; it.knot_5 = 32'sh5;
    send_segment(it);
    // Each denominator zero in turn, then k3-k2, k3-k1 and k3-k0 negative, then all zero.
    it = basic_segment(32'sh20000, 32'sh10000);
    it.knot_3 = it.knot_2; send_segment(it);
    it = basic_segment(32'sh20000, 32'sh10000);
    it.knot_1 = it.knot_3; it.knot_0 = 32'sh0; send_segment(it);
    it = basic_segment(32'sh20000, 32'sh10000);
    it.knot_4 = it.knot_2; send_segment(it);
    it = basic_segment(32'sh20000, 32'sh10000);
    it.knot_0 = it.knot_3; send_segment(it);
    it = basic_segment(32'sh20000, 32'sh10000);
    it.knot_1 = it.knot_4; send_segment(it);
    it = basic_segment(32'sh20000, 32'sh10000);
    it.knot_5 = it.knot_2; send_segment(it);
    it = basic_segment(32'sh20000, 32'sh10000);
    it.knot_3 = 32'sh80000000; send_segment(it);
    send_segment(in_item_t'('0));
    send_segment(in_item_t'('1));
    // Sender pauses until every prediction is matched.
    wait_drained();
  endtask

  // Mostly well-formed windows with random content, the rest raw noise.
  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9, 0) < 8) begin
        send_segment(rand_segment());
      end else begin
        send_segment(noise_segment());
      end
    end
  endtask

  // Stretches with no idling on either side.
  task automatic test_back_to_back(input int count);
    sink_random = 1'b0;
    for (int n = 0; n < count; n++) begin
      send_segment(rand_segment(), 0);
    end
    end_burst();
    sink_random = 1'b1;
  endtask

  // The receiver holds off well past the pipeline depth while items keep
  // coming, so the output queue fills, the pipe stalls and in_ready drops.
  // The receiver ends the hold by itself in its own process.
  task automatic test_backpressure();
    hold_results = 1'b1;
    for (int n = 0; n < LATENCY + 40; n++) begin
      send_segment(rand_segment(), 0);
    end
    end_burst();
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random stalls, an unbroken mode and the long hold-off.
  // -------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_random && out_ready && out_valid) begin
        stall = $urandom_range(9, 0);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_curves.size() == 0) begin
        $display("%t: unexpected result: actual value %h flag %b", $realtime,
                 out_data.curve_value, out_data.span_error);
        error_count++;
      end else begin
        want = expected_curves.pop_front();
        if (out_data.curve_value !== want.curve_value) begin
          $display("%t: curve_value mismatch: expected %h actual %h", $realtime,
                   want.curve_value, out_data.curve_value);
          error_count++;
        end
        if (out_data.span_error !== want.span_error) begin
          $display("%t: span_error mismatch: expected %b actual %b", $realtime,
                   want.span_error, out_data.span_error);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    error_count  = 0;
    idle_cycles  = 0;
    hold_results = 1'b0;
    sink_random  = 1'b1;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(900);
    test_back_to_back(200);
    test_backpressure();
    test_random(400);
    wait_drained();

    repeat (LATENCY + 20) @(negedge clk);
    if (error_count == 0 && expected_curves.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/bspl_pkg.sv
src/bspl_div.sv
src/bspl_mul.sv
src/nonuniform_bspline_eval.sv
src/bspl_chk.sv
verif/nonuniform_bspline_eval_test.sv
